[design/ormt_pkg.sv]
// Package with the shared types, widths and codes of the outstanding request match table.
`default_nettype none

package ormt_pkg;

    localparam int SLOTS  = 128;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int TAG_W  = 32;
    localparam int HND_W  = 16;
    localparam int IDX_W  = 7;

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_REPLY = 2'd2,
        FN_CLEAR = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_ALLOC = 3'd0,
        ST_READ  = 3'd1,
        ST_REPLY = 3'd2,
        ST_DONE  = 3'd3,
        ST_DROP  = 3'd4,
        ST_CLEAR = 3'd5
    } status_t;

    typedef struct packed {
        logic hit;
        logic free;
    } match_t;

endpackage

`default_nettype wire

[design/ormt_in_if.sv]
// Request channel interface of the outstanding request match table.
`default_nettype none

interface ormt_in_if;
    logic                            valid;
    logic                            ready;
    ormt_pkg::func_t                 func;
    logic [ormt_pkg::TAG_W-1:0]      tag;
    logic [ormt_pkg::HND_W-1:0]      reply_handle;

    modport source (output valid, func, tag, reply_handle, input ready);
    modport sink (input valid, func, tag, reply_handle, output ready);
endinterface

`default_nettype wire

[design/ormt_out_if.sv]
// Result channel interface of the outstanding request match table.
`default_nettype none

interface ormt_out_if;
    logic                            valid;
    logic                            ready;
    ormt_pkg::status_t               status;
    logic [ormt_pkg::IDX_W-1:0]      slot_index;
    logic [ormt_pkg::HND_W-1:0]      done_handle;
    logic                            release_valid;
    logic [ormt_pkg::HND_W-1:0]      release_handle;
    logic                            table_flushed;

    modport source (output valid, status, slot_index, done_handle, release_valid,
                    release_handle, table_flushed, input ready);
    modport sink (input valid, status, slot_index, done_handle, release_valid,
                  release_handle, table_flushed, output ready);
endinterface

`default_nettype wire

[design/ormt_handle_ram.sv]
// Generic single-port-write, registered-read RAM for the reply handles.
`default_nettype none

module ormt_handle_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/ormt_tag_store.sv]
// Tag memory with per-slot valid bits and the shared tag comparator.
`default_nettype none

module ormt_tag_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [ormt_pkg::SLOT_W-1:0]   rd_addr,
    input  logic [ormt_pkg::TAG_W-1:0]    key,
    input  logic                          wr_en,
    input  logic [ormt_pkg::SLOT_W-1:0]   wr_addr,
    input  logic [ormt_pkg::TAG_W-1:0]    wr_data,
    input  logic                          clear_all,
    output ormt_pkg::match_t              match
);
    import ormt_pkg::*;

    logic [TAG_W-1:0] mem [SLOTS];
    logic [TAG_W-1:0] rd_data_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;
    logic             rd_valid_reg;
    logic [TAG_W-1:0] eff_tag;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clear_all)
        begin
            valid_next = '0;
        end
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // A slot that is not valid reads as a free slot with tag zero.
    assign eff_tag    = rd_valid_reg ? rd_data_reg : '0;
    assign match.hit  = (eff_tag == key);
    assign match.free = (eff_tag == '0);

endmodule

`default_nettype wire

[design/outstanding_request_match_table_core.sv]
// Top level of the outstanding request match table: sequencer, mark bits and result register.
//
// The request channel (req) carries func, tag and reply_handle; the result channel (rsp)
// carries one result beat for every request beat. Both use valid/ready and a beat moves
// at a rising edge with valid and ready high. The block takes one request at a time.
// Write, read and reply requests scan the tag memory one slot at a time, with a registered
// memory read (S_RD) and then a compare (S_CMP) for each slot, stopping at the first
// matching tag. After a hit, or after a write's full scan, the handle read (S_HND), the
// update (S_UPD) and the result hand-off (S_OUT) follow in turn. Clear-all, and a read or
// reply with tag zero, need no scan and go straight to S_OUT. A full table is flushed in
// the same cycle as the write that takes slot 0. The result sits in an output register;
// when the receiver stalls, the block finishes the next request but holds its result
// until the register is free. Reset clears all tags, marks and handle flags at once, so
// no clearing pass is needed, and req.ready is high from the first cycle after reset.
`default_nettype none

module outstanding_request_match_table_core (
    input  logic       clk,
    input  logic       rst_n,
    ormt_in_if.sink    req,
    ormt_out_if.source rsp
);
    import ormt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_HND,
        S_UPD,
        S_OUT
    } state_t;

    state_t            state_reg;
    func_t             func_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [HND_W-1:0]  hnd_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] sel_reg;
    logic [SLOT_W-1:0] free_idx_reg;
    logic              free_found_reg;
    logic              flush_reg;
    logic [SLOTS-1:0]  read_seen_reg;
    logic [SLOTS-1:0]  has_handle_reg;

    status_t           res_status_reg;
    logic [IDX_W-1:0]  res_idx_reg;
    logic [HND_W-1:0]  res_done_reg;
    logic              res_rel_v_reg;
    logic [HND_W-1:0]  res_rel_h_reg;
    logic              res_flush_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [HND_W-1:0]  out_done_reg;
    logic              out_rel_v_reg;
    logic [HND_W-1:0]  out_rel_h_reg;
    logic              out_flush_reg;

    match_t            match;
    logic [HND_W-1:0]  hnd_rd_data;
    logic              tag_rd_en;
    logic              tag_wr_en;
    logic [TAG_W-1:0]  tag_wr_data;
    logic              clear_all;
    logic              hnd_wr_en;
    logic              accept;
    logic              last_slot;
    logic              cur_rs;
    logic              cur_hh;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign last_slot = (idx_reg == SLOT_W'(SLOTS - 1));
    assign cur_rs    = read_seen_reg[sel_reg];
    assign cur_hh    = has_handle_reg[sel_reg];

    always_comb
    begin
        tag_rd_en   = (state_reg == S_RD);
        tag_wr_en   = 1'b0;
        tag_wr_data = tag_reg;
        hnd_wr_en   = 1'b0;
        clear_all   = accept && (req.func == FN_CLEAR);
        if (state_reg == S_UPD)
        begin
            case (func_reg)
                FN_WRITE:
                begin
                    tag_wr_en = 1'b1;
                    clear_all = flush_reg;
                end
                FN_READ:
                begin
                    tag_wr_en   = cur_hh;
                    tag_wr_data = '0;
                end
                FN_REPLY:
                begin
                    hnd_wr_en   = 1'b1;
                    tag_wr_en   = cur_rs;
                    tag_wr_data = '0;
                end
                default:
                begin
                    tag_wr_en = 1'b0;
                end
            endcase
        end
    end

    ormt_tag_store u_tag_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (tag_rd_en),
        .rd_addr   (idx_reg),
        .key       (tag_reg),
        .wr_en     (tag_wr_en),
        .wr_addr   (sel_reg),
        .wr_data   (tag_wr_data),
        .clear_all (clear_all),
        .match     (match)
    );

    ormt_handle_ram #(
        .DEPTH (SLOTS),
        .WIDTH (HND_W)
    ) u_handle_ram (
        .clk     (clk),
        .wr_en   (hnd_wr_en),
        .wr_addr (sel_reg),
        .wr_data (hnd_reg),
        .rd_en   (state_reg == S_HND),
        .rd_addr (sel_reg),
        .rd_data (hnd_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            func_reg       <= FN_WRITE;
            tag_reg        <= '0;
            hnd_reg        <= '0;
            idx_reg        <= '0;
            sel_reg        <= '0;
            free_idx_reg   <= '0;
            free_found_reg <= 1'b0;
            flush_reg      <= 1'b0;
            read_seen_reg  <= '0;
            has_handle_reg <= '0;
            res_status_reg <= ST_DROP;
            res_idx_reg    <= '0;
            res_done_reg   <= '0;
            res_rel_v_reg  <= 1'b0;
            res_rel_h_reg  <= '0;
            res_flush_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_DROP;
            out_idx_reg    <= '0;
            out_done_reg   <= '0;
            out_rel_v_reg  <= 1'b0;
            out_rel_h_reg  <= '0;
            out_flush_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg       <= req.func;
                        tag_reg        <= req.tag;
                        hnd_reg        <= req.reply_handle;
                        idx_reg        <= '0;
                        free_found_reg <= 1'b0;
                        flush_reg      <= 1'b0;
                        res_idx_reg    <= '0;
                        res_done_reg   <= '0;
                        res_rel_v_reg  <= 1'b0;
                        res_rel_h_reg  <= '0;
                        res_flush_reg  <= 1'b0;
                        if (req.func == FN_CLEAR)
                        begin
                            res_status_reg <= ST_CLEAR;
                            state_reg      <= S_OUT;
                        end
                        else if (req.func != FN_WRITE && req.tag == '0)
                        begin
                            res_status_reg <= ST_DROP;
                            state_reg      <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end

                S_RD:
                begin
                    state_reg <= S_CMP;
                end

                S_CMP:
                begin
                    if (match.free && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= idx_reg;
                    end
                    if (match.hit)
                    begin
                        sel_reg   <= idx_reg;
                        state_reg <= S_HND;
                    end
                    else if (last_slot)
                    begin
                        if (func_reg == FN_WRITE)
                        begin
                            if (free_found_reg)
                            begin
                                sel_reg <= free_idx_reg;
                            end
                            else if (match.free)
                            begin
                                sel_reg <= idx_reg;
                            end
                            else
                            begin
                                sel_reg   <= '0;
                                flush_reg <= 1'b1;
                            end
                            state_reg <= S_HND;
                        end
                        else
                        begin
                            res_status_reg <= ST_DROP;
                            state_reg      <= S_OUT;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end

                S_HND:
                begin
                    state_reg <= S_UPD;
                end

                S_UPD:
                begin
                    res_idx_reg <= IDX_W'(sel_reg);
                    case (func_reg)
                        FN_WRITE:
                        begin
                            read_seen_reg[sel_reg]  <= 1'b0;
                            has_handle_reg[sel_reg] <= 1'b0;
                            res_status_reg          <= ST_ALLOC;
                            res_rel_v_reg           <= cur_hh;
                            res_rel_h_reg           <= cur_hh ? hnd_rd_data : '0;
                            res_flush_reg           <= flush_reg;
                        end
                        FN_READ:
                        begin
                            if (cur_hh)
                            begin
                                read_seen_reg[sel_reg]  <= 1'b0;
                                has_handle_reg[sel_reg] <= 1'b0;
                                res_status_reg          <= ST_DONE;
                                res_done_reg            <= hnd_rd_data;
                            end
                            else
                            begin
                                read_seen_reg[sel_reg] <= 1'b1;
                                res_status_reg         <= ST_READ;
                            end
                        end
                        default:
                        begin
                            if (cur_rs)
                            begin
                                read_seen_reg[sel_reg]  <= 1'b0;
                                has_handle_reg[sel_reg] <= 1'b0;
                                res_status_reg          <= ST_DONE;
                                res_done_reg            <= hnd_reg;
                            end
                            else
                            begin
                                has_handle_reg[sel_reg] <= 1'b1;
                                res_status_reg          <= ST_REPLY;
                            end
                        end
                    endcase
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_idx_reg    <= res_idx_reg;
                        out_done_reg   <= res_done_reg;
                        out_rel_v_reg  <= res_rel_v_reg;
                        out_rel_h_reg  <= res_rel_h_reg;
                        out_flush_reg  <= res_flush_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.slot_index     = out_idx_reg;
    assign rsp.done_handle    = out_done_reg;
    assign rsp.release_valid  = out_rel_v_reg;
    assign rsp.release_handle = out_rel_h_reg;
    assign rsp.table_flushed  = out_flush_reg;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("A second request beat was taken while one is in progress.");

    a_flush_is_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.table_flushed |-> rsp.status == ST_ALLOC && rsp.slot_index == '0)
        else $error("A flush was reported other than on a write into slot zero.");

    a_release_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.release_valid |-> rsp.status == ST_ALLOC)
        else $error("A handle was released by an operation other than a write.");

    a_done_handle_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_DONE |-> rsp.done_handle == '0)
        else $error("A done handle was reported without completion.");
`endif

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the outstanding request match table core.
`timescale 1ns / 100ps

module tb;
    import ormt_pkg::*;

    localparam int          ITEMS = 1650;
    localparam int unsigned LIMIT = 3_000_000;
    localparam int          DRAIN = 2 * SLOTS + 8;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] slot;
        logic [HND_W-1:0] done;
        logic             rel;
        logic [HND_W-1:0] rel_hnd;
        logic             flushed;
    } result_t;

    typedef struct packed {
        func_t            fn;
        logic [TAG_W-1:0] tag;
        logic [HND_W-1:0] hnd;
        logic             typed;
        result_t          want;
    } plan_row_t;

    localparam plan_row_t PLAN [23] = '{
        '{FN_READ,  32'h0000_0005, 16'h0000, 1'b1, '{ST_DROP,  7'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_REPLY, 32'h0000_0000, 16'hFFFF, 1'b1, '{ST_DROP,  7'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_WRITE, 32'hFFFF_FFFF, 16'h0000, 1'b1, '{ST_ALLOC, 7'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_WRITE, 32'h0000_0001, 16'hFFFF, 1'b1, '{ST_ALLOC, 7'd1, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_READ,  32'hFFFF_FFFF, 16'h0000, 1'b1, '{ST_READ,  7'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_REPLY, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{ST_DONE,  7'd0, 16'hFFFF, 1'b0, 16'h0000, 1'b0}},
        '{FN_WRITE, 32'h0000_0007, 16'h0000, 1'b1, '{ST_ALLOC, 7'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_REPLY, 32'h0000_0007, 16'h0000, 1'b1, '{ST_REPLY, 7'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_REPLY, 32'h0000_0007, 16'h1234, 1'b1, '{ST_REPLY, 7'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_WRITE, 32'h0000_0007, 16'h0000, 1'b1, '{ST_ALLOC, 7'd0, 16'h0000, 1'b1, 16'h1234, 1'b0}},
        '{FN_REPLY, 32'h0000_0001, 16'hA5A5, 1'b1, '{ST_REPLY, 7'd1, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{ST_CLEAR, 7'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_READ,  32'h0000_0001, 16'h0000, 1'b1, '{ST_DROP,  7'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_WRITE, 32'h0000_0000, 16'h0000, 1'b1, '{ST_ALLOC, 7'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_WRITE, 32'h8000_0000, 16'h0000, 1'b1, '{ST_ALLOC, 7'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_WRITE, 32'h1234_5678, 16'h0000, 1'b1, '{ST_ALLOC, 7'd1, 16'h0000, 1'b1, 16'hA5A5, 1'b0}},
        '{FN_READ,  32'h1234_5678, 16'h0000, 1'b0, '0},
        '{FN_READ,  32'h1234_5678, 16'h0000, 1'b0, '0},
        '{FN_REPLY, 32'h1234_5678, 16'h0000, 1'b1, '{ST_DONE,  7'd1, 16'h0000, 1'b0, 16'h0000, 1'b0}},
        '{FN_WRITE, 32'hDEAD_BEEF, 16'h0000, 1'b0, '0},
        '{FN_REPLY, 32'hDEAD_BEEF, 16'h8001, 1'b0, '0},
        '{FN_READ,  32'hDEAD_BEEF, 16'h0000, 1'b1, '{ST_DONE,  7'd1, 16'h8001, 1'b0, 16'h0000, 1'b0}},
        '{FN_REPLY, 32'h8000_0000, 16'h5A5A, 1'b1, '{ST_REPLY, 7'd0, 16'h0000, 1'b0, 16'h0000, 1'b0}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        sink_ready = 1'b0;
    bit          quiet = 1'b0;
    int          hold_left = 0;
    int          mismatches = 0;
    int          sent = 0;
    int unsigned cycles = 0;

    logic [TAG_W-1:0] held_tag [SLOTS];
    logic             read_mark [SLOTS];
    logic             handle_held [SLOTS];
    logic [HND_W-1:0] held_handle [SLOTS];

    result_t pending_results [$];

    ormt_in_if  req ();
    ormt_out_if rsp ();

    assign rsp.ready = sink_ready;

    outstanding_request_match_table_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int lookup(logic [TAG_W-1:0] tg);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (held_tag[i] == tg)
            begin
                return i;
            end
        end
        return SLOTS;
    endfunction

    function automatic void drop_all_tags();
        for (int i = 0; i < SLOTS; i++)
        begin
            held_tag[i] = '0;
        end
    endfunction

    function automatic result_t table_apply(func_t fn, logic [TAG_W-1:0] tg,
                                            logic [HND_W-1:0] hn);
        result_t r;
        int      s;
        r = '0;
        r.status = ST_DROP;
        if (fn == FN_CLEAR)
        begin
            drop_all_tags();
            r.status = ST_CLEAR;
        end
        else if (fn == FN_WRITE)
        begin
            s = lookup(tg);
            if (s == SLOTS)
            begin
                s = lookup('0);
            end
            if (s == SLOTS)
            begin
                drop_all_tags();
                r.flushed = 1'b1;
                s = 0;
            end
            held_tag[s] = tg;
            read_mark[s] = 1'b0;
            if (handle_held[s])
            begin
                r.rel = 1'b1;
                r.rel_hnd = held_handle[s];
            end
            handle_held[s] = 1'b0;
            r.status = ST_ALLOC;
            r.slot = IDX_W'(s);
        end
        else
        begin
            s = (tg != '0) ? lookup(tg) : SLOTS;
            if (s < SLOTS)
            begin
                r.slot = IDX_W'(s);
                if (fn == FN_READ)
                begin
                    read_mark[s] = 1'b1;
                    r.status = ST_READ;
                end
                else
                begin
                    held_handle[s] = hn;
                    handle_held[s] = 1'b1;
                    r.status = ST_REPLY;
                end
                if (read_mark[s] && handle_held[s])
                begin
                    r.status = ST_DONE;
                    r.done = held_handle[s];
                    held_tag[s] = '0;
                    read_mark[s] = 1'b0;
                    handle_held[s] = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [TAG_W-1:0] pick_live_tag();
        int live [$];
        for (int i = 0; i < SLOTS; i++)
        begin
            if (held_tag[i] != '0)
            begin
                live.push_back(i);
            end
        end
        if (live.size() == 0)
        begin
            return $urandom();
        end
        return held_tag[live[$urandom_range(0, live.size() - 1)]];
    endfunction

    task automatic push_request(func_t fn, logic [TAG_W-1:0] tg, logic [HND_W-1:0] hn,
                                logic typed, result_t want);
        int      gap;
        result_t predicted;
        gap = 0;
        while (!quiet && $urandom_range(0, 99) < 21)
        begin
            gap++;
        end
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.func <= fn;
        req.tag <= tg;
        req.reply_handle <= hn;
        do @(posedge clk); while (!req.ready);
        predicted = table_apply(fn, tg, hn);
        pending_results.push_back(typed ? want : predicted);
        sent++;
    endtask

    task automatic flag_mismatch(string msg);
        if (mismatches < 100)
        begin
            $display("mismatch at cycle %0d: %s", cycles, msg);
        end
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            sink_ready <= 1'b0;
        end
        else if (quiet)
        begin
            sink_ready <= 1'b1;
        end
        else if ($urandom_range(0, 999) == 0)
        begin
            hold_left <= $urandom_range(5, 200);
            sink_ready <= 1'b0;
        end
        else
        begin
            sink_ready <= ($urandom_range(0, 99) >= 21);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                flag_mismatch("result beat with nothing pending");
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.status !== want.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            rsp.status, want.status));
                if (rsp.slot_index !== want.slot)
                    flag_mismatch($sformatf("slot_index %0d, expected %0d",
                                            rsp.slot_index, want.slot));
                if (rsp.done_handle !== want.done)
                    flag_mismatch($sformatf("done_handle %h, expected %h",
                                            rsp.done_handle, want.done));
                if (rsp.release_valid !== want.rel)
                    flag_mismatch($sformatf("release_valid %b, expected %b",
                                            rsp.release_valid, want.rel));
                if (rsp.release_handle !== want.rel_hnd)
                    flag_mismatch($sformatf("release_handle %h, expected %h",
                                            rsp.release_handle, want.rel_hnd));
                if (rsp.table_flushed !== want.flushed)
                    flag_mismatch($sformatf("table_flushed %b, expected %b",
                                            rsp.table_flushed, want.flushed));
            end
        end
    end

    initial
    begin
        int               fill;
        int               burst_left;
        int               bursts;
        int               pick;
        int               kind;
        func_t            fn;
        logic [TAG_W-1:0] tg;
        logic [HND_W-1:0] hn;
        result_t          flush_want;

        req.valid <= 1'b0;
        req.func <= FN_WRITE;
        req.tag <= '0;
        req.reply_handle <= '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            held_tag[i] = '0;
            read_mark[i] = 1'b0;
            handle_held[i] = 1'b0;
            held_handle[i] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[i])
        begin
            push_request(PLAN[i].fn, PLAN[i].tag, PLAN[i].hnd, PLAN[i].typed, PLAN[i].want);
        end

        // Fill every free slot, then one more write must flush and recycle slot zero.
        fill = 0;
        while (lookup('0) != SLOTS)
        begin
            push_request(FN_WRITE, 32'h0001_0000 + fill, 16'($urandom_range(0, 65535)),
                         1'b0, '0);
            fill++;
        end
        flush_want = '{status: ST_ALLOC, slot: 7'd0, done: 16'h0000, rel: 1'b1,
                       rel_hnd: 16'h5A5A, flushed: 1'b1};
        push_request(FN_WRITE, 32'hC0DE_0001, 16'h0000, 1'b1, flush_want);

        burst_left = 0;
        bursts = 0;
        while (sent < ITEMS)
        begin
            quiet = (sent >= 700 && sent < 1000);
            hn = 16'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            if (burst_left > 0)
            begin
                burst_left--;
                fn = FN_WRITE;
                tg = $urandom();
            end
            else if (pick < 2)
            begin
                fn = FN_CLEAR;
                tg = $urandom();
            end
            else if (pick < 3 && bursts < 3)
            begin
                bursts++;
                burst_left = SLOTS + $urandom_range(1, 8);
                fn = FN_WRITE;
                tg = $urandom();
            end
            else if (pick < 36)
            begin
                fn = FN_WRITE;
                kind = $urandom_range(0, 99);
                if (kind < 70)
                    tg = $urandom();
                else if (kind < 94)
                    tg = pick_live_tag();
                else
                    tg = '0;
            end
            else
            begin
                fn = (pick < 68) ? FN_READ : FN_REPLY;
                if ($urandom_range(0, 99) < 85)
                    tg = pick_live_tag();
                else if ($urandom_range(0, 3) == 0)
                    tg = '0;
                else
                    tg = $urandom();
            end
            push_request(fn, tg, hn, 1'b0, '0);
        end
        quiet = 1'b0;
        req.valid <= 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
